>>> sv/tnp_pkg.sv
// tnp_pkg: shared types, constants and helpers of the three number command parser
// used by tnp_parse_core and three_number_command_parser
// no dependencies
`timescale 1ns / 1ps

package tnp_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int OUT_WIDTH    = 32;
   localparam int BYTE_WIDTH   = 8;
   localparam int FIELD_COUNT  = 3;
   localparam int INDEX_WIDTH  = 2;

   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [3:0]            HEX_TEN    = 4'hA;

   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(FIELD_COUNT - 1);

   typedef logic [NUMBER_WIDTH-1:0] number_type;
   typedef logic [OUT_WIDTH-1:0]    out_number_type;

   typedef enum logic [3:0] {
      PHASE_FIRST    = 4'b0001,
      PHASE_SECOND   = 4'b0010,
      PHASE_MORE     = 4'b0100,
      PHASE_WAIT_END = 4'b1000
   } phase_type;

   typedef struct packed {
      logic           emit;
      out_number_type first_number;
      out_number_type second_number;
      out_number_type third_number;
   } result_type;

   // digit value of a byte, valid flag in bit 4
   function automatic logic [4:0] digit_decode(input logic [BYTE_WIDTH-1:0] c);
      logic [4:0] r;
      logic [BYTE_WIDTH-1:0] d;
      begin
         r = 5'd0;
         d = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            r = {1'b1, d[3:0]};
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = c - CHAR_UPPER_A;
            r = {1'b1, HEX_TEN + d[3:0]};
         end
         return r;
      end
   endfunction

   // stored number to output width
   function automatic out_number_type to_out(input number_type n);
      logic [NUMBER_WIDTH+OUT_WIDTH-1:0] w;
      begin
         w = {{OUT_WIDTH{1'b0}}, n};
         return w[OUT_WIDTH-1:0];
      end
   endfunction

endpackage

>>> sv/tnp_parse_core.sv
// tnp_parse_core: parse state and number accumulators, one byte per step
// depends on tnp_pkg
`timescale 1ns / 1ps

module tnp_parse_core
   import tnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [BYTE_WIDTH-1:0] rx_byte,
   output result_type            result
);

   phase_type              phase_ff, phase_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   number_type             num_ff [FIELD_COUNT];
   number_type             num_in [FIELD_COUNT];

   logic [4:0] dig;
   logic       is_end;
   logic       is_delim;
   number_type cur;
   number_type acc;
   logic       clear;

   always_comb begin
      dig      = digit_decode(rx_byte);
      is_end   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
      is_delim = (rx_byte == CHAR_COMMA) || (rx_byte == CHAR_SPACE);
      cur      = num_ff[0];
      if (index_ff == LAST_INDEX) begin
         cur = num_ff[2];
      end else if (index_ff == 2'd1) begin
         cur = num_ff[1];
      end
      // times ten as two shifts
      acc = (cur << 3) + (cur << 1) + NUMBER_WIDTH'(dig[3:0]);

      phase_in = phase_ff;
      index_in = index_ff;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         num_in[i] = num_ff[i];
      end
      clear = 1'b0;

      if (is_end) begin
         clear = 1'b1;
      end else if (phase_ff == PHASE_WAIT_END) begin
         clear = 1'b1;
      end else if (dig[4]) begin
         case (phase_ff)
            PHASE_FIRST: begin
               num_in[index_ff] = NUMBER_WIDTH'(dig[3:0]);
               phase_in         = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               num_in[index_ff] = acc;
               phase_in         = PHASE_MORE;
            end
            default: begin
               num_in[index_ff] = acc;
               if (index_ff == LAST_INDEX) begin
                  phase_in = PHASE_WAIT_END;
               end
            end
         endcase
      end else if (is_delim) begin
         if (index_ff == LAST_INDEX) begin
            clear = 1'b1;
         end else begin
            index_in = index_ff + 2'd1;
            phase_in = PHASE_FIRST;
         end
      end else begin
         clear = 1'b1;
      end

      if (clear) begin
         phase_in = PHASE_FIRST;
         index_in = '0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            num_in[i] = '0;
         end
      end

      result.emit          = is_end && (index_ff == LAST_INDEX);
      result.first_number  = to_out(num_ff[0]);
      result.second_number = to_out(num_ff[1]);
      result.third_number  = to_out(num_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         index_ff <= '0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            num_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            num_ff[i] <= num_in[i];
         end
      end
   end

endmodule

>>> sv/three_number_command_parser.sv
// three_number_command_parser: input byte register, parse core, result register
// depends on tnp_pkg and tnp_parse_core
// response: end byte goes to the byte register, then rsp_valid is registered at its step
// throughput: one byte per cycle unless rsp_stall holds rsp_valid, set by the parse step
// reset: synchronous, clears both valid flags, phase, field index and numbers
`timescale 1ns / 1ps

module three_number_command_parser
   import tnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_WIDTH-1:0] req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output out_number_type        rsp_first_number,
   output out_number_type        rsp_second_number,
   output out_number_type        rsp_third_number
);

   logic                  byte_valid_ff, byte_valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   out_number_type        first_ff, second_ff, third_ff;

   logic       out_free;
   logic       step;
   logic       req_take;
   result_type result;

   tnp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (byte_ff),
      .result  (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = byte_valid_ff && out_free;
   assign req_stall = byte_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (req_take) begin
         byte_valid_in = 1'b1;
      end else if (step) begin
         byte_valid_in = 1'b0;
      end
      rsp_valid_in = step ? result.emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_rx_byte;
      end
      if (step && result.emit) begin
         first_ff  <= result.first_number;
         second_ff <= result.second_number;
         third_ff  <= result.third_number;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_number  = first_ff;
   assign rsp_second_number = second_ff;
   assign rsp_third_number  = third_ff;

endmodule
